>>> hdl/rpe_pkg.sv
package rpe_pkg;

   // Table geometry and field widths.
   localparam int MAX_REGIONS = 64;
   localparam int FRAME_BITS  = 24;
   localparam int SLOT_BITS   = $clog2(MAX_REGIONS);
   localparam int SCAN_BITS   = $clog2(MAX_REGIONS + 1);
   localparam int COUNT_BITS  = 7;
   localparam int RAMP_BITS   = 16;
   localparam int SHIFT_BITS  = 14;
   localparam int BEGIN_BITS  = FRAME_BITS;
   localparam int END_BITS    = FRAME_BITS + 1;
   localparam int FRAME_W     = FRAME_BITS + 1;
   localparam int ENTRY_BITS  = SHIFT_BITS + END_BITS + BEGIN_BITS;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = RAMP_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RAMP_FRAMES  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REGION_COUNT = 1'b1;

   // Transaction operations.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Arithmetic widths of the ramp weight.
   localparam int Q_BITS       = 16;
   localparam int T_BITS       = Q_BITS + 1;
   localparam int R2_BITS      = RAMP_BITS + 1;
   localparam int DIST_BITS    = FRAME_BITS + 2;
   localparam int SQ_BITS      = 2 * T_BITS;
   localparam int F_BITS       = Q_BITS + 2;
   localparam int WEIGHT_FRAC  = 3 * Q_BITS;
   localparam int W_BITS       = WEIGHT_FRAC + 1;
   localparam int W_LO_BITS    = 25;
   localparam int W_HI_BITS    = W_BITS - W_LO_BITS;
   localparam int ACC_BITS     = WEIGHT_FRAC + SHIFT_BITS;
   localparam int DIV_CNT_BITS = $clog2(Q_BITS);

   localparam logic [T_BITS-1:0] ONE_Q = T_BITS'(1 << Q_BITS);
   localparam logic [F_BITS-1:0] THREE_Q = F_BITS'(3 * (1 << Q_BITS));
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(Q_BITS - 1);

   // Datapath commands.
   localparam int DP_OP_BITS = 4;
   localparam logic [DP_OP_BITS-1:0] DP_NOP    = 4'd0;
   localparam logic [DP_OP_BITS-1:0] DP_LOAD   = 4'd1;
   localparam logic [DP_OP_BITS-1:0] DP_START  = 4'd2;
   localparam logic [DP_OP_BITS-1:0] DP_HIT    = 4'd3;
   localparam logic [DP_OP_BITS-1:0] DP_PREP   = 4'd4;
   localparam logic [DP_OP_BITS-1:0] DP_DECIDE = 4'd5;
   localparam logic [DP_OP_BITS-1:0] DP_DIV    = 4'd6;
   localparam logic [DP_OP_BITS-1:0] DP_MUL_SQ = 4'd7;
   localparam logic [DP_OP_BITS-1:0] DP_MUL_W  = 4'd8;
   localparam logic [DP_OP_BITS-1:0] DP_MUL_LO = 4'd9;
   localparam logic [DP_OP_BITS-1:0] DP_MUL_HI = 4'd10;
   localparam logic [DP_OP_BITS-1:0] DP_ROUND  = 4'd11;
   localparam logic [DP_OP_BITS-1:0] DP_MISS   = 4'd12;
   localparam logic [DP_OP_BITS-1:0] DP_OUT    = 4'd13;

   typedef struct packed {
      logic [DP_OP_BITS-1:0] op;
      logic [SLOT_BITS-1:0]  rd_addr;
   } rpe_cmd_type;

   typedef struct packed {
      logic                 hit_now;
      logic                 zero_ramp;
      logic                 clamp;
      logic [SCAN_BITS-1:0] count;
   } rpe_stat_type;

endpackage

>>> hdl/rpe_channels.sv
interface rpe_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [rpe_pkg::SLOT_BITS-1:0]        region_slot;
   logic [rpe_pkg::BEGIN_BITS-1:0]       region_begin;
   logic [rpe_pkg::END_BITS-1:0]         region_end;
   logic signed [rpe_pkg::SHIFT_BITS-1:0] region_shift;
   logic signed [rpe_pkg::FRAME_W-1:0]   frame;

   modport source (output valid, operation, region_slot, region_begin, region_end,
                   region_shift, frame, input ready);
   modport sink (input valid, operation, region_slot, region_begin, region_end,
                 region_shift, frame, output ready);
endinterface

interface rpe_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rpe_pkg::SHIFT_BITS-1:0] pitch_offset;
   logic                                  in_region;

   modport source (output valid, pitch_offset, in_region, input ready);
   modport sink (input valid, pitch_offset, in_region, output ready);
endinterface

>>> hdl/rpe_ram.sv
module rpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rpe_datapath.sv
module rpe_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [rpe_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [rpe_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  rpe_pkg::rpe_cmd_type                   cmd,
   input  logic [rpe_pkg::SLOT_BITS-1:0]          req_region_slot,
   input  logic [rpe_pkg::BEGIN_BITS-1:0]         req_region_begin,
   input  logic [rpe_pkg::END_BITS-1:0]           req_region_end,
   input  logic signed [rpe_pkg::SHIFT_BITS-1:0]  req_region_shift,
   input  logic signed [rpe_pkg::FRAME_W-1:0]     req_frame,
   output rpe_pkg::rpe_stat_type                  stat,
   output logic signed [rpe_pkg::SHIFT_BITS-1:0]  rsp_pitch_offset,
   output logic                                   rsp_in_region
);
   import rpe_pkg::*;

   // Configuration registers.
   logic [RAMP_BITS-1:0]  ramp_ff, ramp_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Query working registers.
   logic signed [FRAME_W-1:0]    frame_ff, frame_in;
   logic [BEGIN_BITS-1:0]        beg_ff, beg_in;
   logic [END_BITS-1:0]          end_ff, end_in;
   logic signed [SHIFT_BITS-1:0] shift_ff, shift_in;
   logic [R2_BITS-1:0]           r2_ff, r2_in;
   logic [DIST_BITS-1:0]         twod_ff, twod_in;
   logic [SHIFT_BITS-1:0]        mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic [R2_BITS-1:0]           rem_ff, rem_in;
   logic [T_BITS-1:0]            t_ff, t_in;
   logic [SQ_BITS-1:0]           sq_ff, sq_in;
   logic [W_BITS-1:0]            w_ff, w_in;
   logic [ACC_BITS-1:0]          acc_ff, acc_in;
   logic signed [SHIFT_BITS-1:0] res_off_ff, res_off_in;
   logic                         res_hit_ff, res_hit_in;
   logic signed [SHIFT_BITS-1:0] out_off_ff, out_off_in;
   logic                         out_hit_ff, out_hit_in;

   // Table memory.
   logic [ENTRY_BITS-1:0] ram_rd_data;
   logic [BEGIN_BITS-1:0] rd_beg;
   logic [END_BITS-1:0]   rd_end;

   // Combinational helpers.
   logic signed [DIST_BITS-1:0] frame_x, rd_beg_x, rd_end_x, beg_x, end_x;
   logic signed [DIST_BITS-1:0] len, d1, d2, dmin, twice_x;
   logic [R2_BITS-1:0]          twice_ramp;
   logic [R2_BITS:0]            rem2;
   logic [F_BITS-1:0]           fac;
   logic [SQ_BITS+F_BITS-1:0]   wprod;
   logic [SHIFT_BITS+W_LO_BITS-1:0] plo;
   logic [SHIFT_BITS+W_HI_BITS-1:0] phi;
   logic [ACC_BITS-1:0]         rnd;
   logic [SHIFT_BITS-1:0]       qmag;

   rpe_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_REGIONS)) u_table (
      .clock   (clock),
      .wr_en   (cmd.op == DP_LOAD),
      .wr_addr (req_region_slot),
      .wr_data ({req_region_shift, req_region_end, req_region_begin}),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Region bounds compare for the entry now on the read port.
   assign rd_beg   = ram_rd_data[BEGIN_BITS-1:0];
   assign rd_end   = ram_rd_data[BEGIN_BITS +: END_BITS];
   assign frame_x  = {frame_ff[FRAME_W-1], frame_ff};
   assign rd_beg_x = {2'b00, rd_beg};
   assign rd_end_x = {1'b0, rd_end};

   // Distances for the selected region.
   assign beg_x      = {2'b00, beg_ff};
   assign end_x      = {1'b0, end_ff};
   assign len        = end_x - beg_x;
   assign d1         = frame_x - beg_x;
   assign d2         = end_x - frame_x;
   assign dmin       = (d1 < d2) ? d1 : d2;
   assign twice_ramp = {ramp_ff, 1'b0};
   assign twice_x    = {{(DIST_BITS - R2_BITS){1'b0}}, twice_ramp};

   // One restoring divide step, and the smoothstep products.
   assign rem2  = {rem_ff, 1'b0};
   assign fac   = THREE_Q - {t_ff, 1'b0};
   assign wprod = sq_ff * fac;
   assign plo   = mag_ff * w_ff[W_LO_BITS-1:0];
   assign phi   = mag_ff * w_ff[W_BITS-1:W_LO_BITS];
   assign rnd   = acc_ff + (ACC_BITS'(1) << (WEIGHT_FRAC - 1));
   assign qmag  = rnd[ACC_BITS-1:WEIGHT_FRAC];

   // Status toward the controller.
   assign stat.hit_now   = (frame_x >= rd_beg_x) && (frame_x < rd_end_x);
   assign stat.zero_ramp = (r2_ff == '0);
   assign stat.clamp     = (twod_ff >= {{(DIST_BITS - R2_BITS){1'b0}}, r2_ff});
   assign stat.count     = (int'(count_ff) > MAX_REGIONS) ? SCAN_BITS'(MAX_REGIONS)
                                                          : SCAN_BITS'(count_ff);

   // Configuration writes.
   always_comb begin
      ramp_in  = ramp_ff;
      count_in = count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RAMP_FRAMES:  ramp_in  = csr_wdata[RAMP_BITS-1:0];
            CSR_REGION_COUNT: count_in = csr_wdata[COUNT_BITS-1:0];
            default:          ramp_in  = ramp_ff;
         endcase
      end
   end

   // Datapath operations selected by the controller.
   always_comb begin
      frame_in   = frame_ff;
      beg_in     = beg_ff;
      end_in     = end_ff;
      shift_in   = shift_ff;
      r2_in      = r2_ff;
      twod_in    = twod_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      t_in       = t_ff;
      sq_in      = sq_ff;
      w_in       = w_ff;
      acc_in     = acc_ff;
      res_off_in = res_off_ff;
      res_hit_in = res_hit_ff;
      out_off_in = out_off_ff;
      out_hit_in = out_hit_ff;
      case (cmd.op)
         DP_START: begin
            frame_in = req_frame;
         end
         DP_HIT: begin
            beg_in   = rd_beg;
            end_in   = rd_end;
            shift_in = ram_rd_data[ENTRY_BITS-1 -: SHIFT_BITS];
         end
         DP_PREP: begin
            // Ramp in half-frames is the smaller of twice the ramp and the length.
            r2_in   = (len >= twice_x) ? twice_ramp : len[R2_BITS-1:0];
            twod_in = {dmin[FRAME_BITS:0], 1'b0};
            neg_in  = shift_ff[SHIFT_BITS-1];
            mag_in  = shift_ff[SHIFT_BITS-1] ? (~shift_ff + 1'b1) : shift_ff;
         end
         DP_DECIDE: begin
            // Full weight when the distance reaches the ramp; the plain shift
            // serves the zero ramp case.
            t_in       = stat.clamp ? ONE_Q : '0;
            rem_in     = twod_ff[R2_BITS-1:0];
            res_off_in = shift_ff;
            res_hit_in = 1'b1;
         end
         DP_DIV: begin
            if (rem2 >= {1'b0, r2_ff}) begin
               rem_in = R2_BITS'(rem2 - {1'b0, r2_ff});
               t_in   = {t_ff[Q_BITS-1:0], 1'b1};
            end else begin
               rem_in = rem2[R2_BITS-1:0];
               t_in   = {t_ff[Q_BITS-1:0], 1'b0};
            end
         end
         DP_MUL_SQ: begin
            sq_in = t_ff * t_ff;
         end
         DP_MUL_W: begin
            w_in = wprod[W_BITS-1:0];
         end
         DP_MUL_LO: begin
            acc_in = ACC_BITS'(plo);
         end
         DP_MUL_HI: begin
            acc_in = acc_ff + (ACC_BITS'(phi) << W_LO_BITS);
         end
         DP_ROUND: begin
            res_off_in = neg_ff ? (~qmag + 1'b1) : qmag;
            res_hit_in = 1'b1;
         end
         DP_MISS: begin
            res_off_in = '0;
            res_hit_in = 1'b0;
         end
         DP_OUT: begin
            out_off_in = res_off_ff;
            out_hit_in = res_hit_ff;
         end
         default: begin
            frame_in = frame_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff  <= '0;
         count_ff <= '0;
      end else begin
         ramp_ff  <= ramp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff   <= frame_in;
      beg_ff     <= beg_in;
      end_ff     <= end_in;
      shift_ff   <= shift_in;
      r2_ff      <= r2_in;
      twod_ff    <= twod_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      t_ff       <= t_in;
      sq_ff      <= sq_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      res_off_ff <= res_off_in;
      res_hit_ff <= res_hit_in;
      out_off_ff <= out_off_in;
      out_hit_ff <= out_hit_in;
   end

   assign rsp_pitch_offset = out_off_ff;
   assign rsp_in_region    = out_hit_ff;

endmodule

>>> hdl/rpe_controller.sv
module rpe_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_operation,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rpe_pkg::rpe_stat_type stat,
   output rpe_pkg::rpe_cmd_type  cmd
);
   import rpe_pkg::*;

   localparam int ST_BITS = 4;
   localparam logic [ST_BITS-1:0] ST_IDLE   = 4'd0;
   localparam logic [ST_BITS-1:0] ST_SCAN   = 4'd1;
   localparam logic [ST_BITS-1:0] ST_PREP   = 4'd2;
   localparam logic [ST_BITS-1:0] ST_DECIDE = 4'd3;
   localparam logic [ST_BITS-1:0] ST_DIV    = 4'd4;
   localparam logic [ST_BITS-1:0] ST_MUL_SQ = 4'd5;
   localparam logic [ST_BITS-1:0] ST_MUL_W  = 4'd6;
   localparam logic [ST_BITS-1:0] ST_MUL_LO = 4'd7;
   localparam logic [ST_BITS-1:0] ST_MUL_HI = 4'd8;
   localparam logic [ST_BITS-1:0] ST_ROUND  = 4'd9;
   localparam logic [ST_BITS-1:0] ST_DONE   = 4'd10;

   logic [ST_BITS-1:0]      state_ff, state_in;
   logic [SCAN_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept;
   logic                    rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath command.
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = DP_NOP;
      cmd.rd_addr  = rd_idx_ff[SLOT_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  cmd.op = DP_LOAD;
               end else begin
                  cmd.op     = DP_START;
                  rd_idx_in  = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Reads are issued one slot a cycle; the compare trails the read through the registered read port.
            if (cmp_vld_ff && stat.hit_now) begin
               cmd.op     = DP_HIT;
               cmp_vld_in = 1'b0;
               state_in   = ST_PREP;
            end else if (!cmp_vld_ff && (rd_idx_ff >= stat.count)) begin
               cmd.op   = DP_MISS;
               state_in = ST_DONE;
            end else if (rd_idx_ff < stat.count) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         ST_PREP: begin
            cmd.op   = DP_PREP;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.op     = DP_DECIDE;
            div_cnt_in = '0;
            if (stat.zero_ramp) begin
               state_in = ST_DONE;
            end else if (stat.clamp) begin
               state_in = ST_MUL_SQ;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op     = DP_DIV;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            cmd.op   = DP_MUL_SQ;
            state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            cmd.op   = DP_MUL_W;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.op   = DP_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.op   = DP_MUL_HI;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op   = DP_ROUND;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (rsp_free) begin
               cmd.op       = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted query always starts a table scan.
   a_query_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == OP_QUERY)) |=> (state_ff == ST_SCAN))
      else $error("query transaction did not start a scan");

   // The divide step counter rests at zero outside the divide.
   a_div_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (div_cnt_ff == '0))
      else $error("divide counter nonzero outside the divide");

   // A pending compare always follows at least one issued read.
   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cmp_vld_ff) |-> (rd_idx_ff != '0))
      else $error("compare without an issued read");

   // A result shows up only right after the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the done state");

   // A finished query with a free output register is delivered next cycle.
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> rsp_valid_ff)
      else $error("finished result was not delivered");

endmodule

>>> hdl/region_pitch_envelope_core.sv
// Channel     Direction  Handshake          Contents
// req_chan    in         valid/ready        load of a region slot, or a frame query
// rsp_chan    out        valid/ready        weighted pitch offset and region hit flag
// csr_*       in         write enable only  ramp_frames (index 0), region_count (index 1)
//
// A load gives no result. A query that hits slot k raises rsp valid after the scan, a
// 16-step restoring divide, four multiplies and a round; past the ramp the divide is
// skipped, with a zero ramp all of them but the scan; a miss ends once every slot is read.
// The scan reads one slot per cycle until a hit, and the next transaction can be taken
// once the result is in the output register. Reset is synchronous and clears the controller
// and both configuration registers; the region table is undefined until loaded. A new
// transaction is taken while a finished result still waits in the output register; rsp
// stalls hold it there.
module region_pitch_envelope_core (
   input  logic                              clock,
   input  logic                              reset,
   rpe_req_if.sink                           req_chan,
   rpe_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [rpe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rpe_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import rpe_pkg::*;

   rpe_cmd_type  cmd;
   rpe_stat_type stat;

   // Sequencing of scan, divide and multiply steps.
   rpe_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Region table, configuration and weight arithmetic.
   rpe_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .req_region_slot  (req_chan.region_slot),
      .req_region_begin (req_chan.region_begin),
      .req_region_end   (req_chan.region_end),
      .req_region_shift (req_chan.region_shift),
      .req_frame        (req_chan.frame),
      .stat             (stat),
      .rsp_pitch_offset (rsp_chan.pitch_offset),
      .rsp_in_region    (rsp_chan.in_region)
   );

endmodule
